### sv/dotd_pkg.sv
// Package with shared command codes and status types for the dual one-shot timer block.
`default_nettype none

package dotd_pkg;

	// Timer command codes; any other code means no command.
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam int unsigned DUR_W = 16;
	localparam int unsigned DEB_W = 8;

	// Reset value of the debounce limit register.
	localparam logic [DEB_W-1:0] DEB_LIMIT_RST = 8'd20;

	// Status of one timer after the current tick.
	typedef struct packed {
		logic expired;
		logic busy;
	} tmr_status_t;

	// Timer request fields as held in the input stage.
	typedef struct packed {
		logic [1:0]       cmd;
		logic [DUR_W-1:0] dur;
	} tmr_req_t;

endpackage

`default_nettype wire

### sv/dotd_timer.sv
// One-shot tick timer: applies a start or stop command, then runs one tick.
`default_nettype none

module dotd_timer
	import dotd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     advance,
	input  wire tmr_req_t req,
	output tmr_status_t   status
);

	logic [DUR_W-1:0] count_q;
	logic [DUR_W-1:0] limit_q;
	logic             running_q;

	logic [DUR_W-1:0] count_d;
	logic [DUR_W-1:0] limit_d;
	logic             running_d;
	logic [DUR_W-1:0] limit_c;
	logic             running_c;
	logic             expired_d;

	always_comb begin
		limit_c   = limit_q;
		running_c = running_q;
		case (req.cmd)
			CMD_START: begin
				limit_c   = req.dur;
				running_c = 1'b1;
			end
			CMD_STOP: begin
				limit_c   = '0;
				running_c = 1'b0;
			end
			default: begin
			end
		endcase

		count_d   = count_q;
		limit_d   = limit_c;
		running_d = running_c;
		expired_d = 1'b0;
		if (running_c) begin
			if (count_q >= limit_c) begin
				count_d   = '0;
				limit_d   = '0;
				running_d = 1'b0;
				expired_d = 1'b1;
			end else begin
				count_d = count_q + DUR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			limit_q   <= '0;
			running_q <= 1'b0;
		end else if (advance) begin
			count_q   <= count_d;
			limit_q   <= limit_d;
			running_q <= running_d;
		end
	end

	assign status.expired = expired_d;
	assign status.busy    = running_d;

endmodule

`default_nettype wire

### sv/dotd_debounce.sv
// Debounce counter for one active-low input pin.
`default_nettype none

module dotd_debounce
	import dotd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             level,
	input  wire logic [DEB_W-1:0] limit,
	output logic                  active
);

	logic [DEB_W-1:0] count_q;
	logic             flag_q;
	logic [DEB_W-1:0] count_d;
	logic             flag_d;

	always_comb begin
		count_d = '0;
		flag_d  = 1'b0;
		if (!level) begin
			// A low level counts up to the limit, then marks the pin active and wraps.
			if (count_q >= limit) begin
				flag_d = 1'b1;
			end else begin
				count_d = count_q + DEB_W'(1);
				flag_d  = flag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (advance) begin
			count_q <= count_d;
			flag_q  <= flag_d;
		end
	end

	assign active = flag_d;

endmodule

`default_nettype wire

### sv/dual_oneshot_timer_debounce.sv
// Top level of the dual one-shot millisecond timer with two debounced input pins.
//
// Every request on the slave stream is one millisecond tick. It carries start or
// stop commands and durations for the "on" and "off" one-shot timers and the raw
// levels of the backward and forward pins, which are active low. Commands apply
// first, then the tick runs. Each tick yields exactly one result request on the
// master stream: the expired pulses, the busy flags and the qualified pin states.
//
// The configuration channel writes the debounce limit (ticks of steady low level
// before a pin reads active). It is always ready and must be written only while
// no tick is in flight.
//
// A tick passes one input stage and one result register, with the timer and
// debounce update between them. A new tick is accepted in every cycle while the
// receiver keeps taking results, so throughput is then one request per cycle.
// When the receiver stalls, the result register holds its request and the input
// stage still takes one more tick; s_tready drops only when both are full.
// Asynchronous reset empties both stages, clears all timer and debounce state
// and loads the debounce limit with 20.
`default_nettype none

module dual_oneshot_timer_debounce
	import dotd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Tick input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] on_command, [17:2] on_duration, [19:18] off_command,
	// [35:20] off_duration, [36] backward_pin, [37] forward_pin, [39:38] zero
	input  wire logic [39:0] s_tdata,
	// Result output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] on_expired, [1] off_expired, [2] on_busy, [3] off_busy,
	// [4] backward_active, [5] forward_active, [7:6] zero
	output logic [7:0]       m_tdata,
	// Debounce limit write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	logic             valid_s1;
	tmr_req_t         on_req_s1;
	tmr_req_t         off_req_s1;
	logic             bwd_pin_s1;
	logic             fwd_pin_s1;

	logic             valid_s2;
	logic [5:0]       result_s2;

	logic [DEB_W-1:0] deb_limit_q;

	logic             advance;
	tmr_status_t      on_status;
	tmr_status_t      off_status;
	logic             bwd_active;
	logic             fwd_active;

	// The input stage moves into the result register when that register is
	// empty or its request is being taken this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_limit_q <= DEB_LIMIT_RST;
		end else if (cfg_valid) begin
			deb_limit_q <= cfg_data;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			on_req_s1.cmd  <= s_tdata[1:0];
			on_req_s1.dur  <= s_tdata[17:2];
			off_req_s1.cmd <= s_tdata[19:18];
			off_req_s1.dur <= s_tdata[35:20];
			bwd_pin_s1     <= s_tdata[36];
			fwd_pin_s1     <= s_tdata[37];
		end
	end

	dotd_timer u_on_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (on_req_s1),
		.status  (on_status)
	);

	dotd_timer u_off_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (off_req_s1),
		.status  (off_status)
	);

	dotd_debounce u_bwd_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (bwd_pin_s1),
		.limit   (deb_limit_q),
		.active  (bwd_active)
	);

	dotd_debounce u_fwd_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (fwd_pin_s1),
		.limit   (deb_limit_q),
		.active  (fwd_active)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= {fwd_active, bwd_active, off_status.busy, on_status.busy,
				off_status.expired, on_status.expired};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, result_s2};

endmodule

`default_nettype wire

### sv/dotd_checker.sv
// Port-level assertion checker for the dual one-shot timer block, with its bind.
`default_nettype none

module dotd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// A stalled result request keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An expiring timer is no longer running after that tick.
	a_on_exp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[2])
		else $error("on timer busy on its expiry tick");

	a_off_exp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> !m_tdata[3])
		else $error("off timer busy on its expiry tick");

	// With the result register empty the input side never blocks.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind dual_oneshot_timer_debounce dotd_checker u_dotd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
